// File: src/arm_execute_alu_multiply_branch_assert.svh
// assertion macros for the execute stage
// expect clk and rst_n in the scope where they are used
`ifndef ARM_EXECUTE_ALU_MULTIPLY_BRANCH_ASSERT_SVH
`define ARM_EXECUTE_ALU_MULTIPLY_BRANCH_ASSERT_SVH

`ifndef ASSERT_OFF
`define ARM_EX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define ARM_EX_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define ARM_EX_ASSERT(label, prop, msg)
`define ARM_EX_NEVER(label, expr, msg)
`endif

`endif

// File: src/arm_ex_pkg.sv
// shared types and constants of the execute stage
// no dependencies
package arm_ex_pkg;

    localparam int DATA_W = 32;
    localparam int OFF_W  = 24;
    localparam int FLAG_W = 4;

    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    typedef enum logic [1:0] {
        CMD_DP     = 2'd0,
        CMD_MUL    = 2'd1,
        CMD_BRANCH = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13
    } alu_op_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              reg_we;
        logic [FLAG_W-1:0] flags;
    } exec_res_t;

endpackage

// File: src/arm_ex_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module arm_ex_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/arm_ex_alu.sv
// execute datapath: data processing, multiply and branch target
// depends on arm_ex_pkg
module arm_ex_alu
    import arm_ex_pkg::*;
(
    input  logic [1:0]              cmd,
    input  logic [3:0]              alu_op,
    input  logic                    set_flags,
    input  logic                    accumulate,
    input  logic [DATA_W-1:0]       rn,
    input  logic [DATA_W-1:0]       rm,
    input  logic [DATA_W-1:0]       rs,
    input  logic [DATA_W-1:0]       pc,
    input  logic [DATA_W-1:0]       second_operand,
    input  logic                    shifter_carry,
    input  logic signed [OFF_W-1:0] branch_disp,
    input  logic [FLAG_W-1:0]       flags,
    output exec_res_t               res
);

    logic [DATA_W:0]   sub_w;
    logic [DATA_W:0]   rsb_w;
    logic [DATA_W:0]   add_w;
    logic [DATA_W-1:0] prod;
    logic [DATA_W-1:0] mac;
    logic [DATA_W-1:0] ext;

    assign sub_w = {1'b0, rn} - {1'b0, second_operand};
    assign rsb_w = {1'b0, second_operand} - {1'b0, rn};
    assign add_w = {1'b0, rn} + {1'b0, second_operand};
    assign prod  = rm * rs;
    assign mac   = prod + (accumulate ? rn : '0);
    assign ext   = {{(DATA_W - OFF_W - 2){branch_disp[OFF_W-1]}}, branch_disp, 2'b00};

    always_comb
    begin
        logic [DATA_W-1:0] value;
        logic              carry;
        logic              writes;
        logic              ok;
        value  = '0;
        carry  = shifter_carry;
        writes = 1'b1;
        ok     = 1'b1;
        res    = '{value: '0, reg_we: 1'b0, flags: flags};
        case (cmd)
            CMD_DP:
            begin
                case (alu_op)
                    OP_AND: value = rn & second_operand;
                    OP_EOR: value = rn ^ second_operand;
                    OP_SUB:
                    begin
                        value = sub_w[DATA_W-1:0];
                        carry = ~sub_w[DATA_W];
                    end
                    OP_RSB:
                    begin
                        value = rsb_w[DATA_W-1:0];
                        carry = ~rsb_w[DATA_W];
                    end
                    OP_ADD:
                    begin
                        value = add_w[DATA_W-1:0];
                        carry = add_w[DATA_W];
                    end
                    OP_TST:
                    begin
                        value  = rn & second_operand;
                        writes = 1'b0;
                        ok     = set_flags;
                    end
                    OP_TEQ:
                    begin
                        value  = rn ^ second_operand;
                        writes = 1'b0;
                        ok     = set_flags;
                    end
                    OP_CMP:
                    begin
                        value  = sub_w[DATA_W-1:0];
                        carry  = ~sub_w[DATA_W];
                        writes = 1'b0;
                        ok     = set_flags;
                    end
                    OP_ORR: value = rn | second_operand;
                    OP_MOV: value = second_operand;
                    default: ok = 1'b0;
                endcase
                if (ok)
                begin
                    res.value  = value;
                    res.reg_we = writes;
                    if (set_flags)
                    begin
                        res.flags[FLAG_N] = value[DATA_W-1];
                        res.flags[FLAG_Z] = (value == '0);
                        res.flags[FLAG_C] = carry;
                    end
                end
            end
            CMD_MUL:
            begin
                res.value  = mac;
                res.reg_we = 1'b1;
                if (set_flags)
                begin
                    res.flags[FLAG_N] = mac[DATA_W-1];
                    res.flags[FLAG_Z] = (mac == '0);
                end
            end
            CMD_BRANCH:
            begin
                res.value  = pc + ext;
                res.reg_we = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// File: src/arm_execute_alu_multiply_branch.sv
// Execute stage of an ARM-like core: one instruction per request, one result per
// request, and a new request can be taken every cycle unless the output stalls.
// Each request passes the s1 and then output registers. The register file is held
// in three copies of a 16 x 32 RAM (one per source operand: Rn, Rm, Rs), all written
// together, with the operands read as the request is taken and forwarded from the
// instruction retiring at that same edge; R15 and the NZCV flags also live in
// flip-flops. The execute cycle is set by the 32 x 32 multiply and accumulate add.
// After reset every register and all flags read as zero, with no clearing pass.
// depends on arm_ex_pkg, arm_ex_ram, arm_ex_alu
`include "arm_execute_alu_multiply_branch_assert.svh"

module arm_execute_alu_multiply_branch
    import arm_ex_pkg::*;
#(
    parameter int REG_COUNT = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   cmd,
    input  logic [3:0]                   alu_op,
    input  logic                         set_flags,
    input  logic                         accumulate,
    input  logic [$clog2(REG_COUNT)-1:0] dest_reg,
    input  logic [$clog2(REG_COUNT)-1:0] first_reg,
    input  logic [$clog2(REG_COUNT)-1:0] mul_reg_a,
    input  logic [$clog2(REG_COUNT)-1:0] mul_reg_b,
    input  logic [DATA_W-1:0]            second_operand,
    input  logic                         shifter_carry,
    input  logic signed [OFF_W-1:0]      branch_disp,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [DATA_W-1:0]            result_value,
    output logic                         reg_written,
    output logic [FLAG_W-1:0]            flags_nzcv
);

    localparam int IDX_W = $clog2(REG_COUNT);
    localparam logic [IDX_W-1:0] PC_IDX = IDX_W'(REG_COUNT - 1);
    localparam int NPORT = 3;

    logic                    s1_valid_reg;
    logic [1:0]              s1_cmd_reg;
    logic [3:0]              s1_op_reg;
    logic                    s1_s_reg;
    logic                    s1_acc_reg;
    logic [IDX_W-1:0]        s1_rd_reg;
    logic [DATA_W-1:0]       s1_op2_reg;
    logic                    s1_shc_reg;
    logic signed [OFF_W-1:0] s1_off_reg;
    logic [NPORT-1:0]        byp_hit_reg;
    logic [NPORT-1:0]        init_reg;
    logic [DATA_W-1:0]       byp_data_reg;
    logic [REG_COUNT-1:0]    written_reg;
    logic [DATA_W-1:0]       pc_reg;
    logic [FLAG_W-1:0]       flags_reg;
    logic                    out_valid_reg;
    logic [DATA_W-1:0]       result_value_reg;
    logic                    reg_written_reg;
    logic [FLAG_W-1:0]       flags_nzcv_reg;

    logic                    accept;
    logic                    advance;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [IDX_W-1:0]        rd_addr [NPORT];
    logic [DATA_W-1:0]       ram_q [NPORT];
    logic [DATA_W-1:0]       op_val [NPORT];
    exec_res_t               res;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign rd_addr[0] = first_reg;
    assign rd_addr[1] = mul_reg_a;
    assign rd_addr[2] = mul_reg_b;

    assign ram_we    = advance && res.reg_we;
    assign ram_waddr = (s1_cmd_reg == CMD_BRANCH) ? PC_IDX : s1_rd_reg;

    for (genvar i = 0; i < NPORT; i++)
    begin : g_rf
        arm_ex_ram #(
            .WIDTH (DATA_W),
            .DEPTH (REG_COUNT)
        ) u_rf (
            .clk   (clk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (res.value),
            .re    (accept),
            .raddr (rd_addr[i]),
            .rdata (ram_q[i])
        );

        // forward the retiring write, entries never written read as zero
        assign op_val[i] = byp_hit_reg[i] ? byp_data_reg :
                           (init_reg[i] ? ram_q[i] : '0);
    end

    arm_ex_alu u_alu (
        .cmd            (s1_cmd_reg),
        .alu_op         (s1_op_reg),
        .set_flags      (s1_s_reg),
        .accumulate     (s1_acc_reg),
        .rn             (op_val[0]),
        .rm             (op_val[1]),
        .rs             (op_val[2]),
        .pc             (pc_reg),
        .second_operand (s1_op2_reg),
        .shifter_carry  (s1_shc_reg),
        .branch_disp    (s1_off_reg),
        .flags          (flags_reg),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            written_reg   <= '0;
            pc_reg        <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= res.flags;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                written_reg[ram_waddr] <= 1'b1;
                if (ram_waddr == PC_IDX)
                begin
                    pc_reg <= res.value;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= cmd;
            s1_op_reg    <= alu_op;
            s1_s_reg     <= set_flags;
            s1_acc_reg   <= accumulate;
            s1_rd_reg    <= dest_reg;
            s1_op2_reg   <= second_operand;
            s1_shc_reg   <= shifter_carry;
            s1_off_reg   <= branch_disp;
            byp_data_reg <= res.value;
            for (int i = 0; i < NPORT; i++)
            begin
                byp_hit_reg[i] <= ram_we && (ram_waddr == rd_addr[i]);
                init_reg[i]    <= written_reg[rd_addr[i]];
            end
        end
        if (advance)
        begin
            result_value_reg <= res.value;
            reg_written_reg  <= res.reg_we;
            flags_nzcv_reg   <= res.flags;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign reg_written  = reg_written_reg;
    assign flags_nzcv   = flags_nzcv_reg;

    `ARM_EX_NEVER(a_no_accept_when_blocked,
        in_ready && s1_valid_reg && out_valid_reg && !out_ready,
        "request taken while pipeline is blocked")
    `ARM_EX_ASSERT(a_branch_updates_pc,
        (advance && s1_cmd_reg == CMD_BRANCH) |=> (pc_reg == result_value_reg && reg_written_reg),
        "branch target not in pc")
    `ARM_EX_NEVER(a_v_flag_kept, flags_reg[FLAG_V], "v flag changed")
    `ARM_EX_ASSERT(a_flags_out_match, (advance) |=> (flags_nzcv_reg == flags_reg),
        "result flags differ from flag state")

endmodule
